[src/stq_pkg.sv]
// shared constants and codes of the sorted timer queue
`timescale 1ns / 1ps
package stq_pkg;
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;
  localparam int MAX_OUT         = 16;
  localparam logic [15:0] WAIT_RESET = 16'd100;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_CANCEL  = 2'd1,
    MODE_REFRESH = 2'd2,
    MODE_EXPIRE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_TIMER = 2'd2,
    ST_ONE_SHOT = 2'd3
  } status_t;
endpackage

[src/sorted_timer_queue.sv]
// sorted timer queue: top level with sequencer over order, deadline and period rams
// add walks the order list to insert by deadline; cancel searches for the entry and shifts the
// entries behind it forward; refresh adds an insert walk; a full table or bad handle skips the walks.
// expire tests entries from the head, shifts the rest forward, then reinserts each due periodic
// timer and frees each one-shot; words then leave one per cycle, the receiver cannot stall them.
// busy holds until the last word, one item at a time; sync reset empties all, max_wait 100
`timescale 1ns / 1ps
module sorted_timer_queue #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
  parameter int TIME_BITS   = stq_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [3:0]           in_handle,
  input  logic [TIME_BITS-1:0] in_deadline,
  input  logic [31:0]          in_period,
  input  logic [TIME_BITS-1:0] in_now,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [3:0]           out_slot,
  output logic                 out_expired,
  output logic                 out_last,
  output logic [15:0]          out_wait_hint,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int KW = $clog2(stq_pkg::MAX_OUT + 1);
  localparam int DW = $clog2(stq_pkg::MAX_OUT);
  localparam int PW = ((CW > KW) ? CW : KW) + 1;
  localparam int SUMW = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [4:0] {
    S_IDLE, S_PER_RD, S_PER_CHK, S_CFREE,
    S_REM, S_REM_RD, S_REM_CMP, S_RSH_CHK, S_RSH_RD, S_RSH_WR,
    S_INS, S_INS_RO, S_INS_RD, S_INS_CMP, S_ISH_CHK, S_ISH_RD, S_ISH_WR, S_INS_PUT,
    S_EX_RO, S_EX_RD, S_EX_CMP, S_EX_END, S_XSH_CHK, S_XSH_RD, S_XSH_WR,
    S_RI_RD, S_RI_CHK, S_EX_NEXT, S_HINT, S_HNT_RD, S_HNT_CMP, S_EMIT
  } state_t;

  state_t                state_r, rem_ret_r, ins_ret_r;
  logic [3:0]            h_r;
  logic [TIME_BITS-1:0]  now_r, dl_r;
  logic [SW-1:0]         slot_r, cur_r;
  logic [PW-1:0]         p_r, i_r, j_r, k_r;
  logic [CW-1:0]         cnt_r;
  logic [TIMER_SLOTS-1:0] used_r;
  logic [SW-1:0]         done_r [stq_pkg::MAX_OUT];
  logic [1:0]            st_r;
  logic [3:0]            rslot_r;
  logic [15:0]           hint_r, max_wait_r;
  logic                  multi_r;

  logic                  ord_we, dl_we, per_we;
  logic [SW-1:0]         ord_waddr, ord_raddr, dl_waddr, dl_raddr, per_waddr, per_raddr;
  logic [SW-1:0]         ord_wdata, ord_rdata;
  logic [TIME_BITS-1:0]  dl_wdata, dl_rdata;
  logic [31:0]           per_wdata, per_rdata;

  logic                  free_found;
  logic [SW-1:0]         free_idx;
  logic [SW-1:0]         done_j;
  logic [TIME_BITS-1:0]  refresh_dl, reinsert_dl, diff;
  logic                  handle_bad;

  stq_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_order (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata));
  stq_ram #(.WIDTH(TIME_BITS), .DEPTH(TIMER_SLOTS)) u_deadline (
    .clk, .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rdata));
  stq_ram #(.WIDTH(32), .DEPTH(TIMER_SLOTS)) u_period (
    .clk, .we(per_we), .waddr(per_waddr), .wdata(per_wdata),
    .raddr(per_raddr), .rdata(per_rdata));

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign done_j    = done_r[DW'(j_r)];
  assign refresh_dl  = TIME_BITS'(SUMW'(now_r) + SUMW'(per_rdata));
  assign reinsert_dl = TIME_BITS'(SUMW'(dl_rdata) + SUMW'(per_rdata));
  assign diff        = dl_rdata - now_r;
  assign handle_bad  = (32'(in_handle) >= TIMER_SLOTS) || !used_r[SW'(in_handle)];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int n = TIMER_SLOTS - 1; n >= 0; n--) begin
      if (!used_r[n]) begin
        free_found = 1'b1;
        free_idx   = SW'(n);
      end
    end
  end

  always_comb begin
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    dl_we = 1'b0;  dl_waddr = '0;  dl_wdata = '0;  dl_raddr = '0;
    per_we = 1'b0; per_waddr = '0; per_wdata = '0; per_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (start && in_mode == stq_pkg::MODE_ADD && free_found) begin
          dl_we = 1'b1;  dl_waddr = free_idx;  dl_wdata = in_deadline;
          per_we = 1'b1; per_waddr = free_idx; per_wdata = in_period;
        end
      end
      S_PER_RD:  per_raddr = SW'(h_r);
      S_PER_CHK: begin
        dl_waddr = SW'(h_r);
        dl_wdata = refresh_dl;
        dl_we    = (per_rdata != 32'd0);
      end
      S_REM_RD:  ord_raddr = SW'(p_r);
      S_RSH_RD:  ord_raddr = SW'(p_r + PW'(1));
      S_RSH_WR: begin
        ord_we = 1'b1; ord_waddr = SW'(p_r); ord_wdata = ord_rdata;
      end
      S_INS_RO:  ord_raddr = SW'(p_r);
      S_INS_RD:  dl_raddr = ord_rdata;
      S_ISH_RD:  ord_raddr = SW'(i_r - PW'(1));
      S_ISH_WR: begin
        ord_we = 1'b1; ord_waddr = SW'(i_r); ord_wdata = ord_rdata;
      end
      S_INS_PUT: begin
        ord_we = 1'b1; ord_waddr = SW'(p_r); ord_wdata = slot_r;
      end
      S_EX_RO:   ord_raddr = SW'(k_r);
      S_EX_RD:   dl_raddr = ord_rdata;
      S_XSH_RD:  ord_raddr = SW'(j_r + k_r);
      S_XSH_WR: begin
        ord_we = 1'b1; ord_waddr = SW'(j_r); ord_wdata = ord_rdata;
      end
      S_RI_RD: begin
        per_raddr = done_j; dl_raddr = done_j;
      end
      S_RI_CHK: begin
        dl_waddr = done_j;
        dl_wdata = reinsert_dl;
        dl_we    = (per_rdata != 32'd0);
      end
      S_HINT:    ord_raddr = '0;
      S_HNT_RD:  dl_raddr = ord_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      rem_ret_r  <= S_HINT;
      ins_ret_r  <= S_HINT;
      used_r     <= '0;
      cnt_r      <= '0;
      max_wait_r <= stq_pkg::WAIT_RESET;
      out_valid  <= 1'b0;
      multi_r    <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        max_wait_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            h_r     <= in_handle;
            now_r   <= in_now;
            multi_r <= 1'b0;
            rslot_r <= in_handle;
            st_r    <= stq_pkg::ST_OK;
            case (in_mode)
              stq_pkg::MODE_ADD: begin
                if (!free_found) begin
                  st_r    <= stq_pkg::ST_FULL;
                  rslot_r <= 4'd0;
                  state_r <= S_HINT;
                end else begin
                  used_r[free_idx] <= 1'b1;
                  slot_r    <= free_idx;
                  dl_r      <= in_deadline;
                  rslot_r   <= 4'(free_idx);
                  ins_ret_r <= S_HINT;
                  state_r   <= S_INS;
                end
              end
              stq_pkg::MODE_CANCEL: begin
                if (handle_bad) begin
                  st_r    <= stq_pkg::ST_NO_TIMER;
                  state_r <= S_HINT;
                end else begin
                  slot_r    <= SW'(in_handle);
                  rem_ret_r <= S_CFREE;
                  state_r   <= S_REM;
                end
              end
              stq_pkg::MODE_REFRESH: begin
                if (handle_bad) begin
                  st_r    <= stq_pkg::ST_NO_TIMER;
                  state_r <= S_HINT;
                end else begin
                  slot_r  <= SW'(in_handle);
                  state_r <= S_PER_RD;
                end
              end
              default: begin
                k_r     <= '0;
                state_r <= S_EX_RO;
              end
            endcase
          end
        end
        S_PER_RD: state_r <= S_PER_CHK;
        S_PER_CHK: begin
          if (per_rdata == 32'd0) begin
            st_r    <= stq_pkg::ST_ONE_SHOT;
            state_r <= S_HINT;
          end else begin
            dl_r      <= refresh_dl;
            rem_ret_r <= S_INS;
            ins_ret_r <= S_HINT;
            state_r   <= S_REM;
          end
        end
        S_CFREE: begin
          used_r[slot_r] <= 1'b0;
          state_r        <= S_HINT;
        end
        // remove slot_r from the order list
        S_REM: begin
          p_r     <= '0;
          state_r <= (cnt_r == '0) ? rem_ret_r : S_REM_RD;
        end
        S_REM_RD: state_r <= S_REM_CMP;
        S_REM_CMP: begin
          if (ord_rdata == slot_r) begin
            state_r <= S_RSH_CHK;
          end else if (p_r + PW'(2) > PW'(cnt_r)) begin
            state_r <= rem_ret_r;
          end else begin
            p_r     <= p_r + PW'(1);
            state_r <= S_REM_RD;
          end
        end
        S_RSH_CHK: begin
          if (p_r + PW'(1) < PW'(cnt_r)) begin
            state_r <= S_RSH_RD;
          end else begin
            cnt_r   <= cnt_r - CW'(1);
            state_r <= rem_ret_r;
          end
        end
        S_RSH_RD: state_r <= S_RSH_WR;
        S_RSH_WR: begin
          p_r     <= p_r + PW'(1);
          state_r <= S_RSH_CHK;
        end
        // insert slot_r with deadline dl_r after all entries not later
        S_INS: begin
          p_r     <= '0;
          i_r     <= PW'(cnt_r);
          state_r <= (cnt_r == '0) ? S_INS_PUT : S_INS_RO;
        end
        S_INS_RO: state_r <= S_INS_RD;
        S_INS_RD: state_r <= S_INS_CMP;
        S_INS_CMP: begin
          if (dl_rdata <= dl_r) begin
            p_r     <= p_r + PW'(1);
            state_r <= (p_r + PW'(1) < PW'(cnt_r)) ? S_INS_RO : S_ISH_CHK;
          end else begin
            state_r <= S_ISH_CHK;
          end
        end
        S_ISH_CHK: state_r <= (i_r > p_r) ? S_ISH_RD : S_INS_PUT;
        S_ISH_RD:  state_r <= S_ISH_WR;
        S_ISH_WR: begin
          i_r     <= i_r - PW'(1);
          state_r <= S_ISH_CHK;
        end
        S_INS_PUT: begin
          cnt_r   <= cnt_r + CW'(1);
          state_r <= ins_ret_r;
        end
        // collect due timers from the head
        S_EX_RO: begin
          if (k_r < PW'(cnt_r) && k_r < PW'(stq_pkg::MAX_OUT)) begin
            state_r <= S_EX_RD;
          end else begin
            state_r <= S_EX_END;
          end
        end
        S_EX_RD: begin
          cur_r   <= ord_rdata;
          state_r <= S_EX_CMP;
        end
        S_EX_CMP: begin
          if (dl_rdata <= now_r) begin
            done_r[DW'(k_r)] <= cur_r;
            k_r              <= k_r + PW'(1);
            state_r          <= S_EX_RO;
          end else begin
            state_r <= S_EX_END;
          end
        end
        S_EX_END: begin
          j_r     <= '0;
          rslot_r <= 4'd0;
          state_r <= (k_r == '0) ? S_HINT : S_XSH_CHK;
        end
        S_XSH_CHK: begin
          if (j_r + k_r < PW'(cnt_r)) begin
            state_r <= S_XSH_RD;
          end else begin
            cnt_r   <= CW'(PW'(cnt_r) - k_r);
            j_r     <= '0;
            state_r <= S_RI_RD;
          end
        end
        S_XSH_RD: state_r <= S_XSH_WR;
        S_XSH_WR: begin
          j_r     <= j_r + PW'(1);
          state_r <= S_XSH_CHK;
        end
        // periodic timers go back in, one-shot timers are freed
        S_RI_RD: state_r <= S_RI_CHK;
        S_RI_CHK: begin
          if (per_rdata != 32'd0) begin
            slot_r    <= done_j;
            dl_r      <= reinsert_dl;
            ins_ret_r <= S_EX_NEXT;
            state_r   <= S_INS;
          end else begin
            used_r[done_j] <= 1'b0;
            state_r        <= S_EX_NEXT;
          end
        end
        S_EX_NEXT: begin
          if (j_r + PW'(1) < k_r) begin
            j_r     <= j_r + PW'(1);
            state_r <= S_RI_RD;
          end else begin
            j_r     <= '0;
            multi_r <= 1'b1;
            state_r <= S_HINT;
          end
        end
        S_HINT: begin
          if (cnt_r == '0) begin
            hint_r  <= max_wait_r;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_HNT_RD;
          end
        end
        S_HNT_RD: state_r <= S_HNT_CMP;
        S_HNT_CMP: begin
          if (diff[TIME_BITS-1]) begin
            hint_r <= 16'd0;
          end else if (diff > TIME_BITS'(max_wait_r)) begin
            hint_r <= max_wait_r;
          end else begin
            hint_r <= 16'(diff);
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid     <= 1'b1;
          out_status    <= st_r;
          out_wait_hint <= hint_r;
          if (multi_r) begin
            out_slot    <= 4'(done_j);
            out_expired <= 1'b1;
            out_last    <= (j_r + PW'(1) == k_r);
            j_r         <= j_r + PW'(1);
            if (j_r + PW'(1) == k_r) begin
              state_r <= S_IDLE;
            end
          end else begin
            out_slot    <= rslot_r;
            out_expired <= 1'b0;
            out_last    <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[src/stq_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[tb/stq_checker.sv]
// checker for the sorted timer queue: tracks timer state, predicts each result word and compares
`timescale 1ns / 1ps
module stq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_handle,
  input  logic [47:0] in_deadline,
  input  logic [31:0] in_period,
  input  logic [47:0] in_now,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_slot,
  input  logic        out_expired,
  input  logic        out_last,
  input  logic [15:0] out_wait_hint,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    stq_pkg::status_t status;
    logic [3:0]  slot;
    logic        expired;
    logic        last;
    logic [15:0] wait_hint;
  } timer_word_t;

  logic        used [16];
  logic [47:0] due_at [16];
  logic [31:0] interval [16];
  logic [3:0]  order [16];
  int          depth;
  logic [15:0] wait_cap;
  timer_word_t expected_words[$];

  function automatic void unlink(logic [3:0] s);
    int p;
    p = 0;
    while (p < depth && order[p] != s) p++;
    if (p >= depth) return;
    for (; p + 1 < depth; p++) order[p] = order[p + 1];
    depth--;
  endfunction

  // ties go behind every entry with an equal deadline
  function automatic void link_sorted(logic [3:0] s);
    int p;
    p = 0;
    if (depth >= 16) return;
    while (p < depth && due_at[order[p]] <= due_at[s]) p++;
    for (int i = depth; i > p; i--) order[i] = order[i - 1];
    order[p] = s;
    depth++;
  endfunction

  function automatic logic [15:0] head_wait(logic [47:0] now);
    logic [47:0] diff;
    if (depth == 0) return wait_cap;
    diff = due_at[order[0]] - now;
    if (diff[47]) return 16'd0;
    return (diff > {32'd0, wait_cap}) ? wait_cap : diff[15:0];
  endfunction

  function automatic void push_word(stq_pkg::status_t st, logic [3:0] sl, logic ex,
                                    logic la, logic [15:0] wh);
    timer_word_t w;
    w.status = st;
    w.slot = sl;
    w.expired = ex;
    w.last = la;
    w.wait_hint = wh;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_timer_op(stq_pkg::mode_t m, logic [3:0] h, logic [47:0] dl,
                                           logic [31:0] per, logic [47:0] now);
    logic [3:0] fired [16];
    int k;
    int free_slot;
    logic [15:0] wh;
    case (m)
      stq_pkg::MODE_ADD: begin
        free_slot = -1;
        for (int i = 15; i >= 0; i--) if (!used[i]) free_slot = i;
        if (free_slot < 0) begin
          push_word(stq_pkg::ST_FULL, 4'd0, 1'b0, 1'b1, head_wait(now));
        end else begin
          used[free_slot] = 1'b1;
          due_at[free_slot] = dl;
          interval[free_slot] = per;
          link_sorted(free_slot[3:0]);
          push_word(stq_pkg::ST_OK, free_slot[3:0], 1'b0, 1'b1, head_wait(now));
        end
      end
      stq_pkg::MODE_CANCEL, stq_pkg::MODE_REFRESH: begin
        if (!used[h]) begin
          push_word(stq_pkg::ST_NO_TIMER, h, 1'b0, 1'b1, head_wait(now));
        end else if (m == stq_pkg::MODE_CANCEL) begin
          unlink(h);
          used[h] = 1'b0;
          push_word(stq_pkg::ST_OK, h, 1'b0, 1'b1, head_wait(now));
        end else if (interval[h] == 32'd0) begin
          push_word(stq_pkg::ST_ONE_SHOT, h, 1'b0, 1'b1, head_wait(now));
        end else begin
          unlink(h);
          due_at[h] = now + {16'd0, interval[h]};
          link_sorted(h);
          push_word(stq_pkg::ST_OK, h, 1'b0, 1'b1, head_wait(now));
        end
      end
      default: begin
        k = 0;
        while (k < depth && k < stq_pkg::MAX_OUT && due_at[order[k]] <= now) begin
          fired[k] = order[k];
          k++;
        end
        if (k == 0) begin
          push_word(stq_pkg::ST_OK, 4'd0, 1'b0, 1'b1, head_wait(now));
        end else begin
          for (int j = 0; j + k < depth; j++) order[j] = order[j + k];
          depth -= k;
          for (int j = 0; j < k; j++) begin
            if (interval[fired[j]] != 32'd0) begin
              due_at[fired[j]] = due_at[fired[j]] + {16'd0, interval[fired[j]]};
              link_sorted(fired[j]);
            end else begin
              used[fired[j]] = 1'b0;
            end
          end
          wh = head_wait(now);
          for (int j = 0; j < k; j++)
            push_word(stq_pkg::ST_OK, fired[j], 1'b1, j + 1 == k, wh);
        end
      end
    endcase
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    timer_word_t w;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) used[i] = 1'b0;
      depth = 0;
      wait_cap = stq_pkg::WAIT_RESET;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) wait_cap = cfg_data;
      if (start && !busy)
        predict_timer_op(stq_pkg::mode_t'(in_mode), in_handle, in_deadline, in_period,
                         in_now);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: slot %0d", out_slot);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (out_status != w.status) begin
            $error("status: expected %0d, got %0d", w.status, out_status);
            errors++;
          end
          if (out_slot != w.slot) begin
            $error("slot: expected %0d, got %0d", w.slot, out_slot);
            errors++;
          end
          if (out_expired != w.expired) begin
            $error("expired: expected %0d, got %0d", w.expired, out_expired);
            errors++;
          end
          if (out_last != w.last) begin
            $error("last: expected %0d, got %0d", w.last, out_last);
            errors++;
          end
          if (out_wait_hint != w.wait_hint) begin
            $error("wait_hint: expected %0d, got %0d", w.wait_hint, out_wait_hint);
            errors++;
          end
        end
      end
    end
    pending = expected_words.size();
  end
endmodule

[tb/sorted_timer_queue_tb.sv]
// top of the sorted timer queue testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module sorted_timer_queue_tb;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = stq_pkg::MODE_EXPIRE;
  logic [3:0]  in_handle = '0;
  logic [47:0] in_deadline = '0;
  logic [31:0] in_period = '0;
  logic [47:0] in_now = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_slot;
  logic        out_expired;
  logic        out_last;
  logic [15:0] out_wait_hint;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_pct;
  int          quiet_cycles;
  logic [47:0] clock_ms;

  sorted_timer_queue dut (.*);
  stq_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial quiet_cycles = 0;

  task automatic send_op(stq_pkg::mode_t m, logic [3:0] h, logic [47:0] dl, logic [31:0] per,
                         logic [47:0] now);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_handle <= h;
    in_deadline <= dl;
    in_period <= per;
    in_now <= now;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_wait_cap(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_timer_ops(int n);
    logic [47:0] dl;
    logic [31:0] per;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      dl = clock_ms + $urandom_range(0, 200);
      per = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(1, 150);
      if ($urandom_range(9) == 0) dl = 48'({$urandom, $urandom});
      if ($urandom_range(19) == 0) per = $urandom;
      if (pick < 35) begin
        send_op(stq_pkg::MODE_ADD, 4'($urandom), dl, per, clock_ms);
      end else if (pick < 50) begin
        send_op(stq_pkg::MODE_CANCEL, 4'($urandom), 48'({$urandom, $urandom}), $urandom,
                clock_ms);
      end else if (pick < 65) begin
        send_op(stq_pkg::MODE_REFRESH, 4'($urandom), 48'({$urandom, $urandom}), $urandom,
                clock_ms);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 120);
        if ($urandom_range(15) == 0) clock_ms = 48'({$urandom, $urandom});
        send_op(stq_pkg::MODE_EXPIRE, 4'($urandom), 48'({$urandom, $urandom}), $urandom,
                clock_ms);
      end
    end
  endtask

  initial begin
    idle_pct = 32;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unknown handle, one-shot and wrapping periodic timers
    send_op(stq_pkg::MODE_EXPIRE, 4'd0, '0, '0, '0);
    send_op(stq_pkg::MODE_REFRESH, 4'd5, '0, '0, 48'd7);
    send_op(stq_pkg::MODE_ADD, 4'd0, 48'd10, 32'd0, '0);
    send_op(stq_pkg::MODE_ADD, 4'd15, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(stq_pkg::MODE_REFRESH, 4'd0, '0, '0, 48'd3);
    send_op(stq_pkg::MODE_REFRESH, 4'd1, '0, '0, 48'hFFFF_FFFF_FFF0);
    // equal deadlines keep insertion order, then the table fills up
    for (int i = 0; i < 15; i++) send_op(stq_pkg::MODE_ADD, 4'd0, 48'd5, i[31:0], 48'd1);
    send_op(stq_pkg::MODE_CANCEL, 4'd3, '0, '0, 48'd1);
    send_op(stq_pkg::MODE_EXPIRE, 4'd0, '0, '0, 48'hFFFF_FFFF_FFFF);
    send_op(stq_pkg::MODE_EXPIRE, 4'd0, '0, '0, 48'hFFFF_FFFF_FFFF);
    drain();

    clock_ms = 48'({$urandom, $urandom});
    write_wait_cap(16'd0);
    random_timer_ops(140);
    drain();

    idle_pct = 85;
    write_wait_cap(16'hFFFF);
    random_timer_ops(140);
    drain();

    idle_pct = 0;
    write_wait_cap(16'($urandom_range(1, 300)));
    random_timer_ops(150);
    drain();

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
